// ----- hw/rtl/mtt_pkg.sv -----
// Shared types and constants for the Manhattan trapezoid transform.
// Used by the channel interfaces, the top level, the point placer and the checker.
package mtt_pkg;

	// Field widths
	localparam int SRC_W   = 28;
	localparam int COORD_W = 32;
	localparam int IDX_W   = 3;

	typedef logic signed [SRC_W-1:0]   src_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	// Edge slope codes
	typedef enum logic [1:0] {
		SLOPE_VERT  = 2'd0,
		SLOPE_RIGHT = 2'd1,
		SLOPE_LEFT  = 2'd2,
		SLOPE_BAD   = 2'd3
	} slope_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_BOX     = 2'd0,
		KIND_TRAP    = 2'd1,
		KIND_ILLEGAL = 2'd2
	} kind_t;

	// Bit positions inside the orientation register
	localparam int ORIENT_NEG_X = 0;
	localparam int ORIENT_NEG_Y = 1;
	localparam int ORIENT_SWAP  = 2;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_ORIENTATION = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET_X    = 3'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y    = 3'd2;
	localparam logic [IDX_W-1:0] REG_WIN_X_MIN   = 3'd3;
	localparam logic [IDX_W-1:0] REG_WIN_Y_MIN   = 3'd4;
	localparam logic [IDX_W-1:0] REG_WIN_X_MAX   = 3'd5;
	localparam logic [IDX_W-1:0] REG_WIN_Y_MAX   = 3'd6;

	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	// Placement settings handed to each point placer
	typedef struct packed {
		logic [2:0] orient;
		src_t       off_x;
		src_t       off_y;
	} place_cfg_t;

endpackage

// ----- hw/rtl/mtt_if.sv -----
// Valid/ready channel interfaces for shape words and result words.
// Depends on mtt_pkg for the field types.
interface mtt_shape_if;
	import mtt_pkg::*;

	logic   valid;
	logic   ready;
	src_t   left_x;
	src_t   bottom_y;
	src_t   right_x;
	src_t   top_y;
	slope_t left_slope;
	slope_t right_slope;

	modport source (output valid, left_x, bottom_y, right_x, top_y, left_slope, right_slope,
		input ready);
	modport sink (input valid, left_x, bottom_y, right_x, top_y, left_slope, right_slope,
		output ready);
endinterface

interface mtt_result_if;
	import mtt_pkg::*;

	logic   valid;
	logic   ready;
	kind_t  kind;
	coord_t pt0_x;
	coord_t pt0_y;
	coord_t pt1_x;
	coord_t pt1_y;
	coord_t pt2_x;
	coord_t pt2_y;
	coord_t pt3_x;
	coord_t pt3_y;

	modport source (output valid, kind, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y,
		input ready);
	modport sink (input valid, kind, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y,
		output ready);
endinterface

// ----- hw/rtl/mtt_place.sv -----
// Places one point by a Manhattan orientation and an offset.
// Depends on mtt_pkg; instantiated once per corner by the top level.
module mtt_place (
	input  mtt_pkg::place_cfg_t cfg,
	input  mtt_pkg::coord_t     src_x,
	input  mtt_pkg::coord_t     src_y,
	output mtt_pkg::coord_t     dst_x,
	output mtt_pkg::coord_t     dst_y
);
	import mtt_pkg::*;

	coord_t u;
	coord_t v;
	coord_t off_x;
	coord_t off_y;

	// Optional swap of the source axes
	assign u = cfg.orient[ORIENT_SWAP] ? src_y : src_x;
	assign v = cfg.orient[ORIENT_SWAP] ? src_x : src_y;

	assign off_x = {{(COORD_W-SRC_W){cfg.off_x[SRC_W-1]}}, cfg.off_x};
	assign off_y = {{(COORD_W-SRC_W){cfg.off_y[SRC_W-1]}}, cfg.off_y};

	// Negation folds into the offset add as a subtract
	assign dst_x = cfg.orient[ORIENT_NEG_X] ? (off_x - u) : (off_x + u);
	assign dst_y = cfg.orient[ORIENT_NEG_Y] ? (off_y - v) : (off_y + v);

endmodule

// ----- hw/rtl/manhattan_trapezoid_transform.sv -----
// Manhattan trapezoid transform, top level: configuration registers and a
// four-stage pipeline. Depends on mtt_pkg, mtt_if and mtt_place.
//
// The block takes one shape word per clock and returns one result word per shape, in order.
// After its shape is accepted, a result passes through an input register, a stage that
// derives the four source corners from the slopes and the height, a stage that places each
// corner by the orientation and offset, and a result register that forms the clipped box,
// passes the corners on or zeroes an illegal shape. Every stage holds when the result side
// stalls, so throughput is one word per cycle whenever the result port is ready. Configuration
// writes take effect on the next cycle and are meant to be made while no shape is in flight.
module manhattan_trapezoid_transform (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [mtt_pkg::IDX_W-1:0]  wr_index,
	input  logic [mtt_pkg::COORD_W-1:0] wr_data,
	mtt_shape_if.sink                  shape,
	mtt_result_if.source               result
);
	import mtt_pkg::*;

	// Configuration registers
	logic [2:0] orient_q;
	src_t       off_x_q;
	src_t       off_y_q;
	coord_t     win_x_min_q;
	coord_t     win_y_min_q;
	coord_t     win_x_max_q;
	coord_t     win_y_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q    <= '0;
			off_x_q     <= '0;
			off_y_q     <= '0;
			win_x_min_q <= COORD_MIN;
			win_y_min_q <= COORD_MIN;
			win_x_max_q <= COORD_MAX;
			win_y_max_q <= COORD_MAX;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ORIENTATION: orient_q    <= wr_data[2:0];
				REG_OFFSET_X:    off_x_q     <= wr_data[SRC_W-1:0];
				REG_OFFSET_Y:    off_y_q     <= wr_data[SRC_W-1:0];
				REG_WIN_X_MIN:   win_x_min_q <= wr_data;
				REG_WIN_Y_MIN:   win_y_min_q <= wr_data;
				REG_WIN_X_MAX:   win_x_max_q <= wr_data;
				REG_WIN_Y_MAX:   win_y_max_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Stall chain: each stage moves when it is empty or the next one moves
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic adv_2, adv_3, adv_o;

	assign adv_o       = !out_valid_q || result.ready;
	assign adv_3       = !valid_s3 || adv_o;
	assign adv_2       = !valid_s2 || adv_3;
	assign shape.ready = !valid_s1 || adv_2;

	// Stage 1: input register
	src_t   lx_s1, by_s1, rx_s1, ty_s1;
	slope_t ls_s1, rs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (shape.ready) begin
			valid_s1 <= shape.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shape.valid && shape.ready) begin
			lx_s1 <= shape.left_x;
			by_s1 <= shape.bottom_y;
			rx_s1 <= shape.right_x;
			ty_s1 <= shape.top_y;
			ls_s1 <= shape.left_slope;
			rs_s1 <= shape.right_slope;
		end
	end

	// Source corners from slopes and height
	coord_t lx_w, rx_w, by_w, ty_w, h_w, lh_w, rh_w;
	coord_t x0_w, x1_w, x2_w, x3_w;
	kind_t  kind_w;

	assign lx_w = {{(COORD_W-SRC_W){lx_s1[SRC_W-1]}}, lx_s1};
	assign rx_w = {{(COORD_W-SRC_W){rx_s1[SRC_W-1]}}, rx_s1};
	assign by_w = {{(COORD_W-SRC_W){by_s1[SRC_W-1]}}, by_s1};
	assign ty_w = {{(COORD_W-SRC_W){ty_s1[SRC_W-1]}}, ty_s1};
	assign h_w  = ty_w - by_w;
	assign lh_w = lx_w + h_w;
	assign rh_w = rx_w - h_w;

	always_comb begin
		case (ls_s1)
			SLOPE_VERT: begin
				x0_w = lx_w;
				x3_w = lx_w;
			end
			SLOPE_RIGHT: begin
				x0_w = lx_w;
				x3_w = lh_w;
			end
			default: begin
				x0_w = lh_w;
				x3_w = lx_w;
			end
		endcase
		case (rs_s1)
			SLOPE_VERT: begin
				x1_w = rx_w;
				x2_w = rx_w;
			end
			SLOPE_RIGHT: begin
				x1_w = rh_w;
				x2_w = rx_w;
			end
			default: begin
				x1_w = rx_w;
				x2_w = rh_w;
			end
		endcase
		if (ls_s1 == SLOPE_VERT && rs_s1 == SLOPE_VERT) begin
			kind_w = KIND_BOX;
		end else if (ls_s1 == SLOPE_BAD || rs_s1 == SLOPE_BAD) begin
			kind_w = KIND_ILLEGAL;
		end else begin
			kind_w = KIND_TRAP;
		end
	end

	// Stage 2: source corners
	coord_t x0_s2, x1_s2, x2_s2, x3_s2, by_s2, ty_s2;
	kind_t  kind_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_2) begin
			x0_s2   <= x0_w;
			x1_s2   <= x1_w;
			x2_s2   <= x2_w;
			x3_s2   <= x3_w;
			by_s2   <= by_w;
			ty_s2   <= ty_w;
			kind_s2 <= kind_w;
		end
	end

	// Place the four corners
	place_cfg_t pcfg;
	coord_t     px_w [4];
	coord_t     py_w [4];

	assign pcfg = '{orient: orient_q, off_x: off_x_q, off_y: off_y_q};

	mtt_place u_place0 (.cfg(pcfg), .src_x(x0_s2), .src_y(by_s2),
		.dst_x(px_w[0]), .dst_y(py_w[0]));
	mtt_place u_place1 (.cfg(pcfg), .src_x(x1_s2), .src_y(by_s2),
		.dst_x(px_w[1]), .dst_y(py_w[1]));
	mtt_place u_place2 (.cfg(pcfg), .src_x(x2_s2), .src_y(ty_s2),
		.dst_x(px_w[2]), .dst_y(py_w[2]));
	mtt_place u_place3 (.cfg(pcfg), .src_x(x3_s2), .src_y(ty_s2),
		.dst_x(px_w[3]), .dst_y(py_w[3]));

	// Stage 3: placed corners
	coord_t px_s3 [4];
	coord_t py_s3 [4];
	kind_t  kind_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && adv_3) begin
			px_s3   <= px_w;
			py_s3   <= py_w;
			kind_s3 <= kind_s2;
		end
	end

	// Box from corners 0 and 2, clipped to the window; an empty clip passes as is
	coord_t bx_min_w, bx_max_w, by_min_w, by_max_w;
	coord_t cx_min_w, cx_max_w, cy_min_w, cy_max_w;
	coord_t r_w [8];

	always_comb begin
		bx_min_w = (px_s3[0] < px_s3[2]) ? px_s3[0] : px_s3[2];
		bx_max_w = (px_s3[0] < px_s3[2]) ? px_s3[2] : px_s3[0];
		by_min_w = (py_s3[0] < py_s3[2]) ? py_s3[0] : py_s3[2];
		by_max_w = (py_s3[0] < py_s3[2]) ? py_s3[2] : py_s3[0];
		cx_min_w = (bx_min_w < win_x_min_q) ? win_x_min_q : bx_min_w;
		cx_max_w = (bx_max_w > win_x_max_q) ? win_x_max_q : bx_max_w;
		cy_min_w = (by_min_w < win_y_min_q) ? win_y_min_q : by_min_w;
		cy_max_w = (by_max_w > win_y_max_q) ? win_y_max_q : by_max_w;
		case (kind_s3)
			KIND_BOX: begin
				r_w = '{cx_min_w, cy_min_w, cx_max_w, cy_max_w, '0, '0, '0, '0};
			end
			KIND_TRAP: begin
				r_w = '{px_s3[0], py_s3[0], px_s3[1], py_s3[1],
					px_s3[2], py_s3[2], px_s3[3], py_s3[3]};
			end
			default: begin
				r_w = '{'0, '0, '0, '0, '0, '0, '0, '0};
			end
		endcase
	end

	// Result register
	coord_t r_q [8];
	kind_t  kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_o) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && adv_o) begin
			r_q    <= r_w;
			kind_q <= kind_s3;
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind  = kind_q;
	assign result.pt0_x = r_q[0];
	assign result.pt0_y = r_q[1];
	assign result.pt1_x = r_q[2];
	assign result.pt1_y = r_q[3];
	assign result.pt2_x = r_q[4];
	assign result.pt2_y = r_q[5];
	assign result.pt3_x = r_q[6];
	assign result.pt3_y = r_q[7];

endmodule

// ----- hw/rtl/mtt_checker.sv -----
// Port-level checks on the result channel of the trapezoid transform.
// Depends on mtt_pkg; attached to the top level by the bind at the end of this file.
module mtt_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [1:0]           res_kind,
	input mtt_pkg::coord_t      pt0_x,
	input mtt_pkg::coord_t      pt0_y,
	input mtt_pkg::coord_t      pt1_x,
	input mtt_pkg::coord_t      pt1_y,
	input mtt_pkg::coord_t      pt2_x,
	input mtt_pkg::coord_t      pt2_y,
	input mtt_pkg::coord_t      pt3_x,
	input mtt_pkg::coord_t      pt3_y
);
	import mtt_pkg::*;

	// A stalled result word keeps its valid.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// A stalled result word keeps its kind, pt0_x and pt1_y.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_kind) && $stable(pt0_x) && $stable(pt1_y))
		else $error("result word changed while stalled");

	// A box uses only its first two points.
	a_box_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_BOX |->
			pt2_x == '0 && pt2_y == '0 && pt3_x == '0 && pt3_y == '0)
		else $error("box result with nonzero unused corners");

	// An illegal shape carries no coordinates.
	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_ILLEGAL |->
			pt0_x == '0 && pt0_y == '0 && pt1_x == '0 && pt1_y == '0 &&
			pt2_x == '0 && pt2_y == '0 && pt3_x == '0 && pt3_y == '0)
		else $error("illegal result with nonzero coordinates");

endmodule

bind manhattan_trapezoid_transform mtt_checker u_mtt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_kind  (result.kind),
	.pt0_x     (result.pt0_x),
	.pt0_y     (result.pt0_y),
	.pt1_x     (result.pt1_x),
	.pt1_y     (result.pt1_y),
	.pt2_x     (result.pt2_x),
	.pt2_y     (result.pt2_y),
	.pt3_x     (result.pt3_x),
	.pt3_y     (result.pt3_y)
);

// ----- sim/tb_manhattan_trapezoid_transform.sv -----
// Self-checking testbench for manhattan_trapezoid_transform: directed and random shape words,
// predicted results checked in order against the result channel under random idling.
// Depends on mtt_pkg, mtt_if (mtt_shape_if, mtt_result_if) and the block itself.
`timescale 1ns / 1ps

module tb_manhattan_trapezoid_transform;
	import mtt_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam src_t SRC_MIN = {1'b1, {(SRC_W-1){1'b0}}};
	localparam src_t SRC_MAX = {1'b0, {(SRC_W-1){1'b1}}};

	typedef struct packed {
		src_t   left_x;
		src_t   bottom_y;
		src_t   right_x;
		src_t   top_y;
		slope_t left_slope;
		slope_t right_slope;
	} shape_word_t;

	// pt[0] = pt0_x, pt[1] = pt0_y, ... pt[7] = pt3_y
	typedef struct packed {
		kind_t                     kind;
		logic [7:0][COORD_W-1:0]   pt;
	} result_word_t;

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_index;
	logic [COORD_W-1:0]  wr_data;

	mtt_shape_if  shape ();
	mtt_result_if result ();

	manhattan_trapezoid_transform u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.shape    (shape),
		.result   (result)
	);

	// Mirror of the configuration registers, kept in step with every write.
	logic [2:0] orient_q      = 3'd0;
	src_t       off_x_q       = '0;
	src_t       off_y_q       = '0;
	coord_t     win_x_min_q   = COORD_MIN;
	coord_t     win_y_min_q   = COORD_MIN;
	coord_t     win_x_max_q   = COORD_MAX;
	coord_t     win_y_max_q   = COORD_MAX;

	result_word_t pending_results[$];
	result_word_t got_word;
	result_word_t want_word;
	int           fail_count = 0;

	// Sender and receiver idling controls.
	int burst_left = 0;
	int burst_max  = 8;
	int gap_max    = 4;
	int hold_left  = 0;
	bit rx_free    = 1'b0;
	int rx_mode    = 0;
	int mode_left  = 0;
	int rx_cycle   = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("manhattan_trapezoid_transform verification failed");
		$finish;
	end

	// Places one source point by the orientation, then adds the offset.
	function automatic void place_point(input longint sx, input longint sy,
		output longint ox, output longint oy);
		longint u;
		longint v;
		u = orient_q[ORIENT_SWAP] ? sy : sx;
		v = orient_q[ORIENT_SWAP] ? sx : sy;
		if (orient_q[ORIENT_NEG_X]) u = -u;
		if (orient_q[ORIENT_NEG_Y]) v = -v;
		ox = u + longint'(off_x_q);
		oy = v + longint'(off_y_q);
	endfunction

	// Works out the result word that one shape word gives under the current setup.
	function automatic result_word_t predict_result(input shape_word_t s);
		result_word_t r;
		longint lx, by, rx, ty, h;
		longint ax, ay, bx, bb, xmin, xmax, ymin, ymax;
		longint px, py;
		longint sx[4];
		longint sy[4];
		r = '0;
		lx = longint'($signed(s.left_x));
		by = longint'($signed(s.bottom_y));
		rx = longint'($signed(s.right_x));
		ty = longint'($signed(s.top_y));
		if (s.left_slope == SLOPE_VERT && s.right_slope == SLOPE_VERT) begin
			// Plain rectangle: transformed box, clipped to the window.
			place_point(lx, by, ax, ay);
			place_point(rx, ty, bx, bb);
			xmin = (ax < bx) ? ax : bx;
			xmax = (ax < bx) ? bx : ax;
			ymin = (ay < bb) ? ay : bb;
			ymax = (ay < bb) ? bb : ay;
			if (xmin < longint'(win_x_min_q)) xmin = longint'(win_x_min_q);
			if (xmax > longint'(win_x_max_q)) xmax = longint'(win_x_max_q);
			if (ymin < longint'(win_y_min_q)) ymin = longint'(win_y_min_q);
			if (ymax > longint'(win_y_max_q)) ymax = longint'(win_y_max_q);
			r.kind  = KIND_BOX;
			r.pt[0] = xmin[31:0];
			r.pt[1] = ymin[31:0];
			r.pt[2] = xmax[31:0];
			r.pt[3] = ymax[31:0];
		end else if (s.left_slope == SLOPE_BAD || s.right_slope == SLOPE_BAD) begin
			r.kind = KIND_ILLEGAL;
		end else begin
			// Four corners from the slopes and the height, each one placed.
			h = ty - by;
			case (s.left_slope)
				SLOPE_VERT: begin
					sx[0] = lx;
					sx[3] = lx;
				end
				SLOPE_RIGHT: begin
					sx[0] = lx;
					sx[3] = lx + h;
				end
				default: begin
					sx[3] = lx;
					sx[0] = lx + h;
				end
			endcase
			case (s.right_slope)
				SLOPE_VERT: begin
					sx[1] = rx;
					sx[2] = rx;
				end
				SLOPE_RIGHT: begin
					sx[2] = rx;
					sx[1] = rx - h;
				end
				default: begin
					sx[1] = rx;
					sx[2] = rx - h;
				end
			endcase
			sy[0] = by;
			sy[1] = by;
			sy[2] = ty;
			sy[3] = ty;
			r.kind = KIND_TRAP;
			for (int i = 0; i < 4; i++) begin
				place_point(sx[i], sy[i], px, py);
				r.pt[2*i]   = px[31:0];
				r.pt[2*i+1] = py[31:0];
			end
		end
		return r;
	endfunction

	function automatic shape_word_t make_shape(input src_t lx, input src_t by, input src_t rx,
		input src_t ty, input slope_t ls, input slope_t rs);
		shape_word_t s;
		s.left_x      = lx;
		s.bottom_y    = by;
		s.right_x     = rx;
		s.top_y       = ty;
		s.left_slope  = ls;
		s.right_slope = rs;
		return s;
	endfunction

	// Random shape word: mostly legal shapes, with extremes and noise mixed in.
	function automatic shape_word_t random_shape();
		shape_word_t s;
		int pick;
		pick = $urandom_range(0, 3);
		case (pick)
			0: begin
				s.left_x   = src_t'($urandom);
				s.bottom_y = src_t'($urandom);
				s.right_x  = src_t'($urandom);
				s.top_y    = src_t'($urandom);
			end
			1: begin
				s.left_x   = src_t'(int'($urandom_range(0, 8191)) - 4096);
				s.bottom_y = src_t'(int'($urandom_range(0, 8191)) - 4096);
				s.right_x  = s.left_x + src_t'(int'($urandom_range(0, 3000)) - 100);
				s.top_y    = s.bottom_y + src_t'(int'($urandom_range(0, 3000)) - 100);
			end
			2: begin
				s.left_x   = src_t'($urandom);
				s.bottom_y = src_t'($urandom);
				s.right_x  = s.left_x + src_t'($urandom_range(0, 1 << 20));
				s.top_y    = s.bottom_y + src_t'(int'($urandom_range(0, 1 << 16)) - 2000);
			end
			default: begin
				s.left_x   = ($urandom_range(0, 1) != 0) ? SRC_MIN : SRC_MAX;
				s.bottom_y = ($urandom_range(0, 1) != 0) ? SRC_MIN : SRC_MAX;
				s.right_x  = ($urandom_range(0, 1) != 0) ? SRC_MIN : src_t'(-1);
				s.top_y    = ($urandom_range(0, 1) != 0) ? SRC_MAX : src_t'(0);
			end
		endcase
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			s.left_slope  = SLOPE_VERT;
			s.right_slope = SLOPE_VERT;
		end else if (pick < 8) begin
			s.left_slope  = slope_t'($urandom_range(0, 2));
			s.right_slope = slope_t'($urandom_range(0, 2));
		end else if (pick == 8) begin
			s.left_slope  = ($urandom_range(0, 1) != 0) ? SLOPE_BAD : slope_t'($urandom_range(0, 2));
			s.right_slope = (s.left_slope == SLOPE_BAD) ? slope_t'($urandom_range(0, 3)) : SLOPE_BAD;
		end else begin
			s.left_slope  = slope_t'($urandom_range(0, 3));
			s.right_slope = slope_t'($urandom_range(0, 3));
		end
		return s;
	endfunction

	// Writes one register and updates the mirror once the write has taken place.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_ORIENTATION: orient_q    = data[2:0];
			REG_OFFSET_X:    off_x_q     = src_t'(data[SRC_W-1:0]);
			REG_OFFSET_Y:    off_y_q     = src_t'(data[SRC_W-1:0]);
			REG_WIN_X_MIN:   win_x_min_q = coord_t'(data);
			REG_WIN_Y_MIN:   win_y_min_q = coord_t'(data);
			REG_WIN_X_MAX:   win_x_max_q = coord_t'(data);
			REG_WIN_Y_MAX:   win_y_max_q = coord_t'(data);
			default: ;
		endcase
	endtask

	// Offers one shape word, with a random gap between bursts, and records its result.
	task automatic send_shape(input shape_word_t s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				shape.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		shape.valid       <= 1'b1;
		shape.left_x      <= s.left_x;
		shape.bottom_y    <= s.bottom_y;
		shape.right_x     <= s.right_x;
		shape.top_y       <= s.top_y;
		shape.left_slope  <= s.left_slope;
		shape.right_slope <= s.right_slope;
		do @(posedge clk); while (shape.ready !== 1'b1);
		pending_results.push_back(predict_result(s));
	endtask

	// Stops offering and waits until every expected result word has come out.
	task automatic wait_drain();
		shape.valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// New setup for all registers: sel 1 gives the low extremes, sel 2 the high ones.
	task automatic configure(input int sel);
		logic [COORD_W-1:0] lo, hi, t;
		int wmode;
		wait_drain();
		if (sel == 1 || sel == 2) begin
			write_reg(REG_ORIENTATION, (sel == 1) ? 32'd0 : 32'd7);
			write_reg(REG_OFFSET_X, (sel == 1) ? SRC_MIN : SRC_MAX);
			write_reg(REG_OFFSET_Y, (sel == 1) ? SRC_MIN : SRC_MAX);
			write_reg(REG_WIN_X_MIN, (sel == 1) ? COORD_MIN : COORD_MAX);
			write_reg(REG_WIN_Y_MIN, (sel == 1) ? COORD_MIN : COORD_MAX);
			write_reg(REG_WIN_X_MAX, (sel == 1) ? COORD_MIN : COORD_MAX);
			write_reg(REG_WIN_Y_MAX, (sel == 1) ? COORD_MIN : COORD_MAX);
		end else begin
			// Upper data bits are junk on purpose; the block keeps only the register width.
			write_reg(REG_ORIENTATION, $urandom);
			for (int k = 0; k < 2; k++) begin
				case ($urandom_range(0, 3))
					0: t = SRC_MIN;
					1: t = SRC_MAX;
					2: t = '0;
					default: t = $urandom;
				endcase
				write_reg(k ? REG_OFFSET_Y : REG_OFFSET_X, t);
			end
			for (int k = 0; k < 2; k++) begin
				wmode = $urandom_range(0, 4);
				lo = $signed($urandom) >>> 3;
				hi = $signed($urandom) >>> 3;
				case (wmode)
					0: begin
						lo = COORD_MIN;
						hi = COORD_MAX;
					end
					1: begin
						if ($signed(lo) > $signed(hi)) begin
							t  = lo;
							lo = hi;
							hi = t;
						end
					end
					2: begin
						if ($signed(lo) < $signed(hi)) begin
							t  = lo;
							lo = hi;
							hi = t;
						end
					end
					3: begin
						lo = $urandom;
						hi = $urandom;
					end
					default: begin
						lo = -int'($urandom_range(0, 4096));
						hi = $urandom_range(0, 4096);
					end
				endcase
				write_reg(k ? REG_WIN_Y_MIN : REG_WIN_X_MIN, lo);
				write_reg(k ? REG_WIN_Y_MAX : REG_WIN_X_MAX, hi);
			end
		end
	endtask

	// Reset setup: boxes at the field extremes, every slope pair, illegal and inverted shapes.
	task automatic test_default_setup();
		send_shape(make_shape(0, 0, 10, 20, SLOPE_VERT, SLOPE_VERT));
		send_shape(make_shape(SRC_MIN, SRC_MIN, SRC_MAX, SRC_MAX, SLOPE_VERT, SLOPE_VERT));
		send_shape(make_shape(SRC_MAX, SRC_MAX, SRC_MIN, SRC_MIN, SLOPE_VERT, SLOPE_VERT));
		for (int ls = 0; ls < 3; ls++) begin
			for (int rs = 0; rs < 3; rs++) begin
				if (ls != 0 || rs != 0)
					send_shape(make_shape(-100, 50, 300, 250, slope_t'(ls), slope_t'(rs)));
			end
		end
		send_shape(make_shape(1, 2, 3, 4, SLOPE_BAD, SLOPE_RIGHT));
		send_shape(make_shape(1, 2, 3, 4, SLOPE_VERT, SLOPE_BAD));
		send_shape(make_shape(1, 2, 3, 4, SLOPE_BAD, SLOPE_BAD));
		// Top below bottom: negative height goes straight through the corner formulas.
		send_shape(make_shape(-40, 500, 900, -300, SLOPE_RIGHT, SLOPE_LEFT));
		send_shape(make_shape(SRC_MIN, SRC_MIN, SRC_MAX, SRC_MAX, SLOPE_RIGHT, SLOPE_LEFT));
	endtask

	// Each of the eight orientations with offsets at their extremes.
	task automatic test_orientations();
		for (int o = 0; o < 8; o++) begin
			wait_drain();
			write_reg(REG_ORIENTATION, o);
			write_reg(REG_OFFSET_X, o[0] ? SRC_MAX : SRC_MIN);
			write_reg(REG_OFFSET_Y, o[0] ? SRC_MIN : SRC_MAX);
			send_shape(make_shape(SRC_MAX, SRC_MIN, SRC_MIN, SRC_MAX, SLOPE_RIGHT, SLOPE_LEFT));
		end
	endtask

	// Box clipping, an empty clip, an ignored register index and an inverted window.
	task automatic test_window_clip();
		wait_drain();
		write_reg(REG_ORIENTATION, 0);
		write_reg(REG_OFFSET_X, 0);
		write_reg(REG_OFFSET_Y, 0);
		write_reg(REG_WIN_X_MIN, -1000);
		write_reg(REG_WIN_X_MAX, 1000);
		write_reg(REG_WIN_Y_MIN, -500);
		write_reg(REG_WIN_Y_MAX, 500);
		send_shape(make_shape(-5000, -200, 300, 9000, SLOPE_VERT, SLOPE_VERT));
		send_shape(make_shape(2000, 0, 3000, 10, SLOPE_VERT, SLOPE_VERT));
		wait_drain();
		write_reg(REG_UNUSED, 32'h0000_0005);
		send_shape(make_shape(-5000, -200, 300, 9000, SLOPE_VERT, SLOPE_VERT));
		wait_drain();
		write_reg(REG_WIN_X_MIN, COORD_MAX);
		write_reg(REG_WIN_X_MAX, COORD_MIN);
		write_reg(REG_WIN_Y_MIN, COORD_MAX);
		write_reg(REG_WIN_Y_MAX, COORD_MIN);
		send_shape(make_shape(7, -7, 70, 700, SLOPE_VERT, SLOPE_VERT));
	endtask

	// Receiver holds off long enough for the pipeline to fill and stall its input.
	task automatic test_backpressure();
		wait_drain();
		gap_max   = 0;
		burst_max = 8;
		hold_left = 120;
		repeat (30) send_shape(random_shape());
		wait_drain();
	endtask

	// Random phases, each under a fresh setup and its own idling profile.
	task automatic test_random();
		for (int phase = 0; phase < 10; phase++) begin
			configure((phase < 2) ? phase + 1 : 0);
			if (phase == 3) begin
				gap_max = 0;
				rx_free = 1'b1;
			end else begin
				gap_max   = $urandom_range(1, 12);
				burst_max = $urandom_range(1, 20);
				rx_free   = 1'b0;
			end
			repeat (70) send_shape(random_shape());
		end
		rx_free = 1'b0;
	endtask

	// Receiver: long hold-offs when asked, otherwise a stall pattern that changes now and then.
	initial begin
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (hold_left > 0) begin
				result.ready <= 1'b0;
				hold_left--;
			end else if (rx_free) begin
				result.ready <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (rx_mode)
					0: result.ready <= 1'b1;
					1: result.ready <= ($urandom_range(0, 3) != 0);
					2: result.ready <= ($urandom_range(0, 3) == 0);
					default: result.ready <= ((rx_cycle % 5) != 0);
				endcase
			end
		end
	end

	// Checks each accepted result word against the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && result.valid === 1'b1 && result.ready === 1'b1) begin
			got_word.kind = result.kind;
			got_word.pt   = {result.pt3_y, result.pt3_x, result.pt2_y, result.pt2_x,
				result.pt1_y, result.pt1_x, result.pt0_y, result.pt0_x};
			if (pending_results.size() == 0) begin
				$display("%0t: result word with none expected: expected nothing, got kind %0d",
					$time, got_word.kind);
				fail_count++;
			end else begin
				want_word = pending_results.pop_front();
				if (got_word.kind !== want_word.kind) begin
					$display("%0t: kind mismatch: expected %0d, got %0d",
						$time, want_word.kind, got_word.kind);
					fail_count++;
				end
				for (int i = 0; i < 8; i++) begin
					if (got_word.pt[i] !== want_word.pt[i]) begin
						$display("%0t: pt%0d_%s mismatch: expected %0d, got %0d", $time, i / 2,
							(i % 2) ? "y" : "x", $signed(want_word.pt[i]),
							$signed(got_word.pt[i]));
						fail_count++;
					end
				end
			end
		end
	end

	// Main sequence: reset once, then each test in turn, then the verdict.
	initial begin
		arst_n            = 1'b0;
		wr_en             = 1'b0;
		wr_index          = REG_ORIENTATION;
		wr_data           = '0;
		shape.valid       = 1'b0;
		shape.left_x      = '0;
		shape.bottom_y    = '0;
		shape.right_x     = '0;
		shape.top_y       = '0;
		shape.left_slope  = SLOPE_VERT;
		shape.right_slope = SLOPE_VERT;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_setup();
		test_orientations();
		test_window_clip();
		test_backpressure();
		test_random();
		wait_drain();
		if (fail_count == 0) begin
			$display("manhattan_trapezoid_transform verification clean");
		end else begin
			$display("manhattan_trapezoid_transform verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/mtt_pkg.sv
hw/rtl/mtt_if.sv
hw/rtl/mtt_place.sv
hw/rtl/manhattan_trapezoid_transform.sv
hw/rtl/mtt_checker.sv
sim/tb_manhattan_trapezoid_transform.sv
